[rtl/core/bmp24_to_rgb565_blitter_core_macros.svh]
// Assertion macros shared by the blitter checker.
// Each macro samples on clk; the reset-gated form ignores cycles with rst high.
`ifndef BMP24_TO_RGB565_BLITTER_CORE_MACROS_SVH
`define BMP24_TO_RGB565_BLITTER_CORE_MACROS_SVH

// Property checked outside reset.
`define BTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also holds across reset.
`define BTR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/btr_pkg.sv]
// Shared types and constants for the BMP24 to RGB565 blitter.
// No dependencies; imported by every module of the block but btr_checker.
`default_nettype none

package btr_pkg;

  localparam int unsigned MAX_SCREEN_SIDE = 1024;
  localparam int unsigned PIXEL_DATA_START = 54;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] RED_MASK = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;
  localparam logic [7:0] KEY_LEVEL = 8'd255;

  localparam logic [5:0] HDR_WIDTH_LO = 6'd18;
  localparam logic [5:0] HDR_WIDTH_HI = 6'd19;
  localparam logic [5:0] HDR_HEIGHT_LO = 6'd22;
  localparam logic [5:0] HDR_HEIGHT_HI = 6'd23;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_X_ORIGIN      = 2'd2,
    REG_Y_ORIGIN      = 2'd3
  } btr_reg_t;

  // One opaque pixel waiting to be placed.
  typedef struct packed {
    logic [15:0] color;       // byte-swapped RGB565
    logic [15:0] column;      // image column
    logic [15:0] row_offset;  // image rows below the top row
  } btr_job_t;

  typedef struct packed {
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [10:0] x_origin;
    logic [10:0] y_origin;
  } btr_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } btr_qstat_t;

  function automatic logic [10:0] clamp_side(input logic [10:0] v);
    logic [10:0] lim;
    lim = 11'(MAX_SCREEN_SIDE);
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bmp24_to_rgb565_blitter_core.sv]
// Top level of the BMP24 to RGB565 blitter: config registers and the
// parser / queue / placement pipeline. Depends on btr_pkg, btr_front,
// btr_queue and btr_back.
//
// Usage:
//   Input channel (in_valid / in_stall, payload in_byte, file_start) carries
//   the bytes of a 24-bit BMP file, one byte per transfer. Raise file_start
//   on the first byte of each file to restart header parsing.
//   Output channel (out_valid / out_stall) carries one framebuffer write per
//   visible, non-white pixel: pixel_column, pixel_row, write_address and the
//   byte-swapped RGB565 pixel_color.
//   Throughput: one byte per cycle sustained; in_stall rises only when the
//   four-entry job queue is full, which happens only while the output is
//   stalled.
//   Path: a pixel's write passes the queue slot (written on the transfer of
//   its red byte), then the clip stage, then the output register.
//   Reset (rst, synchronous) clears the parse state, empties the queue and
//   pipeline, and loads screen 240x320 with origin (0,0).
//   A stalled output holds its payload; the clip stage then holds a visible
//   job, and the input keeps taking bytes until the queue fills.
//   Config writes through the APB port are meant for idle periods only.
`default_nettype none

module bmp24_to_rgb565_blitter_core
  import btr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        file_start,
  // pixel write output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       pixel_column,
  output logic [9:0]       pixel_row,
  output logic [19:0]      write_address,
  output logic [15:0]      pixel_color,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  btr_cfg_t   cfg;
  btr_job_t   front_job;
  btr_job_t   head_job;
  btr_qstat_t qstat;
  logic       take;
  logic       push;
  logic       pop;
  logic       cfg_write;
  btr_reg_t   reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = btr_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Config registers; the write lands on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 11'd240;
      cfg.screen_height <= 11'd320;
      cfg.x_origin      <= '0;
      cfg.y_origin      <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[10:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[10:0];
        REG_X_ORIGIN:      cfg.x_origin      <= pwdata[10:0];
        REG_Y_ORIGIN:      cfg.y_origin      <= pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = {21'b0, cfg.screen_width};
      REG_SCREEN_HEIGHT: prdata = {21'b0, cfg.screen_height};
      REG_X_ORIGIN:      prdata = {21'b0, cfg.x_origin};
      REG_Y_ORIGIN:      prdata = {21'b0, cfg.y_origin};
    endcase
  end

  // Hold input while the queue has no room for a job.
  assign in_stall = qstat.full;
  assign take     = in_valid && !in_stall;

  btr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .in_byte    (in_byte),
    .file_start (file_start),
    .job        (front_job),
    .push       (push)
  );

  btr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (qstat)
  );

  btr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .job_avail     (!qstat.empty),
    .job           (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_column  (pixel_column),
    .pixel_row     (pixel_row),
    .write_address (write_address),
    .pixel_color   (pixel_color)
  );

endmodule

`default_nettype wire

[rtl/core/btr_front.sv]
// Byte parser: header fields, triplet gathering, row padding, color key.
// Depends on btr_pkg.
`default_nettype none

module btr_front
  import btr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       file_start,
  output btr_job_t        job,
  output logic            push
);

  logic [5:0]  header_position, header_position_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  triplet_phase, triplet_phase_next;
  logic [1:0]  padding_left, padding_left_next;
  logic [15:0] held_blue_green, held_blue_green_next;

  logic [15:0] rgb;
  logic [15:0] col_inc;
  logic        is_key;
  logic        red_byte;

  always_comb begin
    // A file start clears the parse state before the byte is used.
    header_position_next = file_start ? '0 : header_position;
    image_width_next     = file_start ? '0 : image_width;
    image_height_next    = file_start ? '0 : image_height;
    column_count_next    = file_start ? '0 : column_count;
    row_count_next       = file_start ? '0 : row_count;
    triplet_phase_next   = file_start ? '0 : triplet_phase;
    padding_left_next    = file_start ? '0 : padding_left;
    held_blue_green_next = file_start ? '0 : held_blue_green;
    red_byte = 1'b0;
    col_inc  = column_count_next + 16'd1;

    if (header_position_next < 6'(PIXEL_DATA_START)) begin
      if (header_position_next == HDR_WIDTH_LO) begin
        image_width_next[7:0] = in_byte;
      end else if (header_position_next == HDR_WIDTH_HI) begin
        image_width_next[15:8] = in_byte;
      end else if (header_position_next == HDR_HEIGHT_LO) begin
        image_height_next[7:0] = in_byte;
      end else if (header_position_next == HDR_HEIGHT_HI) begin
        image_height_next[15:8] = in_byte;
      end
      header_position_next = header_position_next + 6'd1;
    end else if (image_width_next == '0 || row_count_next >= image_height_next) begin
      // Past the image: drop the byte.
    end else if (padding_left_next != '0) begin
      padding_left_next = padding_left_next - 2'd1;
      if (padding_left_next == '0) begin
        column_count_next = '0;
        row_count_next    = row_count_next + 16'd1;
      end
    end else if (triplet_phase_next == 2'd0) begin
      held_blue_green_next[7:0] = in_byte;
      triplet_phase_next = 2'd1;
    end else if (triplet_phase_next == 2'd1) begin
      held_blue_green_next[15:8] = in_byte;
      triplet_phase_next = 2'd2;
    end else begin
      red_byte = 1'b1;
      triplet_phase_next = 2'd0;
      column_count_next  = col_inc;
      if (col_inc == image_width_next) begin
        if (image_width_next[1:0] == 2'd0) begin
          column_count_next = '0;
          row_count_next    = row_count_next + 16'd1;
        end else begin
          padding_left_next = image_width_next[1:0];
        end
      end
    end
  end

  // Job payload is taken from the state as seen by this byte.
  always_comb begin
    logic [15:0] cc;
    logic [15:0] rc;
    logic [15:0] h;
    logic [15:0] bg;
    cc = file_start ? '0 : column_count;
    rc = file_start ? '0 : row_count;
    h  = file_start ? '0 : image_height;
    bg = file_start ? '0 : held_blue_green;
    rgb = {in_byte[7:3] & RED_MASK[7:3], bg[15:10] & GREEN_MASK[7:2], bg[7:3]};
    is_key = (in_byte == KEY_LEVEL) && (bg[15:8] == KEY_LEVEL) && (bg[7:0] == KEY_LEVEL);
    job.color      = {rgb[7:0], rgb[15:8]};
    job.column     = cc;
    job.row_offset = h - 16'd1 - rc;
  end

  assign push = take && red_byte && !is_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      image_width     <= '0;
      image_height    <= '0;
      column_count    <= '0;
      row_count       <= '0;
      triplet_phase   <= '0;
      padding_left    <= '0;
      held_blue_green <= '0;
    end else if (take) begin
      header_position <= header_position_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      triplet_phase   <= triplet_phase_next;
      padding_left    <= padding_left_next;
      held_blue_green <= held_blue_green_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/btr_queue.sv]
// Small job queue between the parser and the placement pipeline.
// Depends on btr_pkg.
`default_nettype none

module btr_queue
  import btr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire btr_job_t push_job,
  input  wire logic     pop,
  output btr_job_t      head_job,
  output btr_qstat_t    status
);

  btr_job_t slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign status.full  = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/btr_back.sv]
// Placement pipeline: origin add and clip, then address and output register.
// Depends on btr_pkg.
`default_nettype none

module btr_back
  import btr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire btr_cfg_t    cfg,
  input  wire logic        job_avail,
  input  wire btr_job_t    job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       pixel_column,
  output logic [9:0]       pixel_row,
  output logic [19:0]      write_address,
  output logic [15:0]      pixel_color
);

  // Clip stage
  logic        a_valid;
  logic        a_visible;
  logic [9:0]  a_col;
  logic [9:0]  a_row;
  logic [10:0] a_stride;
  logic [15:0] a_color;

  logic [10:0] sw;
  logic [10:0] sh;
  logic [17:0] col_s;
  logic [17:0] row_s;
  logic        visible;
  logic        out_ready;
  logic        a_free;
  logic        load_out;
  logic [20:0] row_base;

  assign sw    = clamp_side(cfg.screen_width);
  assign sh    = clamp_side(cfg.screen_height);
  assign col_s = {{7{cfg.x_origin[10]}}, cfg.x_origin} + {2'b00, job.column};
  assign row_s = {{7{cfg.y_origin[10]}}, cfg.y_origin} + {2'b00, job.row_offset};
  assign visible = !col_s[17] && (col_s[16:0] < {6'b0, sw}) &&
                   !row_s[17] && (row_s[16:0] < {6'b0, sh});

  assign out_ready = !out_valid || !out_stall;
  assign load_out  = a_valid && a_visible && out_ready;
  assign a_free    = !a_valid || !a_visible || out_ready;
  assign pop       = job_avail && a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_visible <= visible;
      a_col     <= col_s[9:0];
      a_row     <= row_s[9:0];
      a_stride  <= sw;
      a_color   <= job.color;
    end
  end

  assign row_base = {11'b0, a_row} * {10'b0, a_stride};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_column  <= a_col;
      pixel_row     <= a_row;
      write_address <= row_base[19:0] + {10'b0, a_col};
      pixel_color   <= a_color;
    end
  end

endmodule

`default_nettype wire

[rtl/core/btr_checker.sv]
// Port-level checks for the blitter top level, bound onto it below.
// Depends on bmp24_to_rgb565_blitter_core_macros.svh.
`default_nettype none
`include "bmp24_to_rgb565_blitter_core_macros.svh"

module btr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [19:0] write_address,
  input wire logic [15:0] pixel_color,
  input wire logic        pready
);

  // Reset empties the pipeline and opens the input.
  `BTR_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && !in_stall), "reset did not clear")

  // The queue only fills while the output is held.
  `BTR_ASSERT(a_stall_cause, in_stall |-> $past(out_valid && out_stall), "input stall without output stall")

  // A held transfer keeps its payload.
  `BTR_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(write_address) && $stable(pixel_color)), "stalled output changed")

  `BTR_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind bmp24_to_rgb565_blitter_core btr_checker u_btr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .write_address (write_address),
  .pixel_color   (pixel_color),
  .pready        (pready)
);

`default_nettype wire
